// ===== rtl/fewd_pkg.sv =====
`timescale 1ns / 1ps

package fewd_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int CHANNELS        = 2;
    localparam int CH_W            = 1;
    localparam int DELAY_DEPTH_DEF = 131072;

    localparam int DLY_W  = 17;
    localparam int GAIN_W = 16;
    localparam int TONE_W = 15;
    localparam int MIX_W  = 17;

    localparam int LP_W       = 24;
    localparam int LP_EXTRA   = 8;
    localparam int COEF_SHIFT = 16;
    localparam int OUT_SHIFT  = 24;

    localparam int OPA_W  = LP_W + 1;
    localparam int OPB_W  = MIX_W + 1;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int RES_W  = ACC_W - OUT_SHIFT;

    localparam logic [MIX_W-1:0] UNITY_GAIN = MIX_W'(65536);

    localparam int CFG_AW    = 4;
    localparam int CFG_DW    = 32;
    localparam int REG_IDX_W = CFG_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_DELAY    = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_FEEDBACK = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_TONE     = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_MIX      = REG_IDX_W'(3);

    localparam logic [DLY_W-1:0]  DELAY_RST    = DLY_W'(18522);
    localparam logic [GAIN_W-1:0] FEEDBACK_RST = GAIN_W'(16384);
    localparam logic [TONE_W-1:0] TONE_RST     = TONE_W'(13206);
    localparam logic [MIX_W-1:0]  MIX_RST      = MIX_W'(11796);

    typedef struct packed {
        logic [DLY_W-1:0]  delay_samples;
        logic [GAIN_W-1:0] feedback_gain;
        logic [TONE_W-1:0] tone_coeff;
        logic [MIX_W-1:0]  mix_level;
    } cfg_t;

    typedef struct packed {
        logic                    go;
        logic                    clr;
        logic signed [OPA_W-1:0] a;
        logic signed [OPB_W-1:0] b;
        logic signed [ACC_W-1:0] addend;
    } mac_cmd_t;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [RES_W-1:0] v
    );
        logic signed [RES_W-1:0] hi;
        logic signed [RES_W-1:0] lo;
        hi = RES_W'((1 << (SAMPLE_BITS - 1)) - 1);
        lo = ~hi;
        if (v > hi)
        begin
            return hi[SAMPLE_BITS-1:0];
        end
        if (v < lo)
        begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

// ===== rtl/fewd_cfg.sv =====
`timescale 1ns / 1ps

module fewd_cfg import fewd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output cfg_t              cfg
);

    cfg_t                   cfg_reg;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   idx;

    assign idx   = paddr[CFG_AW-1:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay_samples <= DELAY_RST;
            cfg_reg.feedback_gain <= FEEDBACK_RST;
            cfg_reg.tone_coeff    <= TONE_RST;
            cfg_reg.mix_level     <= MIX_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_DELAY:    cfg_reg.delay_samples <= pwdata[DLY_W-1:0];
                REG_FEEDBACK: cfg_reg.feedback_gain <= pwdata[GAIN_W-1:0];
                REG_TONE:     cfg_reg.tone_coeff    <= pwdata[TONE_W-1:0];
                REG_MIX:      cfg_reg.mix_level     <= pwdata[MIX_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DELAY:    prdata = CFG_DW'(cfg_reg.delay_samples);
            REG_FEEDBACK: prdata = CFG_DW'(cfg_reg.feedback_gain);
            REG_TONE:     prdata = CFG_DW'(cfg_reg.tone_coeff);
            REG_MIX:      prdata = CFG_DW'(cfg_reg.mix_level);
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== rtl/fewd_mac.sv =====
`timescale 1ns / 1ps

// two-stage multiply-accumulate: product registered, then added
module fewd_mac import fewd_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_cmd_t                cmd,
    output logic signed [ACC_W-1:0] acc
);

    logic                     go_reg;
    logic                     clr_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  addend_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    assign acc = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg <= 1'b0;
        end
        else
        begin
            go_reg <= cmd.go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            prod_reg   <= cmd.a * cmd.b;
            addend_reg <= cmd.addend;
            clr_reg    <= cmd.clr;
        end
        if (go_reg)
        begin
            acc_reg <= (clr_reg ? addend_reg : acc_reg) + ACC_W'(prod_reg);
        end
    end

endmodule

// ===== rtl/fewd_mem.sv =====
`timescale 1ns / 1ps

module fewd_mem import fewd_pkg::*; #(
    parameter int ENTRIES = CHANNELS * DELAY_DEPTH_DEF,
    parameter int AW      = $clog2(CHANNELS * DELAY_DEPTH_DEF)
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  logic [SAMPLE_BITS-1:0] wdata,
    input  logic                   re,
    input  logic [AW-1:0]          raddr,
    output logic [SAMPLE_BITS-1:0] rdata
);

    logic [SAMPLE_BITS-1:0] mem [ENTRIES];
    logic [SAMPLE_BITS-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

// ===== rtl/feedback_echo_with_damping.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// in        in_valid / in_stall          left_in, right_in
// out       out_valid / out_stall        left_out, right_out
// config    psel, penable, pwrite        paddr, pwdata, prdata (pready tied high)
//
// Each transaction runs through the accepting state, one address step, nine steps per
// channel through the shared two-stage multiply-accumulate unit and the delay memory's
// single read port, and one step to load the output register.
// in_stall is high while a frame is in work; a finished frame waits in the output
// register, so the next frame is accepted while out_stall holds the previous one.
// No clearing pass after reset: unwritten entries read as zero via position and wrap flag.
module feedback_echo_with_damping import fewd_pkg::*; #(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_AW-1:0]             paddr,
    input  logic [CFG_DW-1:0]             pwdata,
    output logic [CFG_DW-1:0]             prdata,
    output logic                          pready
);

    localparam int POS_W  = $clog2(DELAY_DEPTH);
    localparam int CW     = ((POS_W > DLY_W) ? POS_W : DLY_W) + 1;
    localparam int MEM_N  = CHANNELS * DELAY_DEPTH;
    localparam int MEM_AW = $clog2(MEM_N);

    localparam logic signed [ACC_W-1:0] RND_LP  = ACC_W'(2 ** (COEF_SHIFT - 1));
    localparam logic signed [ACC_W-1:0] RND_OUT = ACC_W'(2 ** (OUT_SHIFT - 1));

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ADDR = 4'd1;
    localparam logic [3:0] ST_READ = 4'd2;
    localparam logic [3:0] ST_DIFF = 4'd3;
    localparam logic [3:0] ST_LP   = 4'd4;
    localparam logic [3:0] ST_LPW  = 4'd5;
    localparam logic [3:0] ST_FB   = 4'd6;
    localparam logic [3:0] ST_DRY  = 4'd7;
    localparam logic [3:0] ST_WET  = 4'd8;
    localparam logic [3:0] ST_SUM  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    cfg_t cfg;

    logic [3:0]       state_reg,     state_next;
    logic [CH_W-1:0]  ch_reg,        ch_next;
    logic [POS_W-1:0] pos_reg,       pos_next;
    logic             wrapped_reg,   wrapped_next;
    logic             out_valid_reg, out_valid_next;
    logic             load_out;
    logic             last_ch;

    logic [POS_W-1:0]              rd_idx_reg;
    logic                          rd_ok_reg;
    logic signed [OPA_W-1:0]       diff_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg   [CHANNELS];
    logic signed [LP_W-1:0]        lp_reg  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] res_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] out_reg [CHANNELS];

    logic [CW-1:0]    delay_ext;
    logic [CW-1:0]    eff_delay;
    logic [CW-1:0]    pos_ext;
    logic [CW-1:0]    rd_full;
    logic             no_wrap;
    logic [MIX_W-1:0] m_eff;

    logic signed [ACC_W-1:0]       acc;
    logic signed [SAMPLE_BITS-1:0] acc_sat;
    logic signed [LP_W-1:0]        s_new;
    logic signed [LP_W-1:0]        x_lp;
    logic signed [LP_W-1:0]        d_lp;
    logic signed [SAMPLE_BITS-1:0] d_val;
    mac_cmd_t                      mac_cmd;

    logic [MEM_AW-1:0]      mem_base;
    logic                   mem_we;
    logic                   mem_re;
    logic [MEM_AW-1:0]      mem_waddr;
    logic [MEM_AW-1:0]      mem_raddr;
    logic [SAMPLE_BITS-1:0] mem_rdata;

    fewd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    fewd_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .acc   (acc)
    );

    fewd_mem #(
        .ENTRIES (MEM_N),
        .AW      (MEM_AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (acc_sat),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign pready    = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign left_out  = out_reg[0];
    assign right_out = out_reg[1];

    // read position, delay clamped to [1, depth-2]
    assign delay_ext = CW'(cfg.delay_samples);
    assign eff_delay = (delay_ext == '0) ? CW'(1) :
                       (delay_ext > CW'(DELAY_DEPTH - 2)) ? CW'(DELAY_DEPTH - 2) : delay_ext;
    assign pos_ext   = CW'(pos_reg);
    assign no_wrap   = (pos_ext >= eff_delay);
    assign rd_full   = no_wrap ? (pos_ext - eff_delay)
                               : (pos_ext + CW'(DELAY_DEPTH) - eff_delay);

    assign m_eff   = (cfg.mix_level > UNITY_GAIN) ? UNITY_GAIN : cfg.mix_level;
    assign acc_sat = sat_sample(acc[ACC_W-1:OUT_SHIFT]);
    assign s_new   = acc[COEF_SHIFT +: LP_W];
    assign d_val   = rd_ok_reg ? mem_rdata : '0;
    assign x_lp    = {x_reg[ch_reg], {LP_EXTRA{1'b0}}};
    assign d_lp    = {d_val, {LP_EXTRA{1'b0}}};
    assign last_ch = (ch_reg == CH_W'(CHANNELS - 1));

    assign mem_base  = MEM_AW'(ch_reg) * MEM_AW'(DELAY_DEPTH);
    assign mem_re    = (state_reg == ST_READ);
    assign mem_raddr = mem_base + MEM_AW'(rd_idx_reg);
    assign mem_we    = (state_reg == ST_WET);
    assign mem_waddr = mem_base + MEM_AW'(pos_reg);

    always_comb
    begin
        mac_cmd = '0;
        unique case (state_reg)
            ST_LP:
            begin
                mac_cmd.go     = 1'b1;
                mac_cmd.clr    = 1'b1;
                mac_cmd.a      = diff_reg;
                mac_cmd.b      = OPB_W'(cfg.tone_coeff);
                mac_cmd.addend = (ACC_W'(lp_reg[ch_reg]) <<< COEF_SHIFT) + RND_LP;
            end
            ST_FB:
            begin
                mac_cmd.go     = 1'b1;
                mac_cmd.clr    = 1'b1;
                mac_cmd.a      = OPA_W'(s_new);
                mac_cmd.b      = OPB_W'(cfg.feedback_gain);
                mac_cmd.addend = (ACC_W'(x_reg[ch_reg]) <<< OUT_SHIFT) + RND_OUT;
            end
            ST_DRY:
            begin
                mac_cmd.go     = 1'b1;
                mac_cmd.clr    = 1'b1;
                mac_cmd.a      = OPA_W'(x_lp);
                mac_cmd.b      = OPB_W'(UNITY_GAIN - m_eff);
                mac_cmd.addend = RND_OUT;
            end
            ST_WET:
            begin
                mac_cmd.go = 1'b1;
                mac_cmd.a  = OPA_W'(lp_reg[ch_reg]);
                mac_cmd.b  = OPB_W'(m_eff);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        pos_next       = pos_reg;
        wrapped_next   = wrapped_reg;
        out_valid_next = out_valid_reg;
        load_out       = 1'b0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                ch_next    = '0;
                state_next = ST_READ;
            end
            ST_READ: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_LP;
            ST_LP:   state_next = ST_LPW;
            ST_LPW:  state_next = ST_FB;
            ST_FB:   state_next = ST_DRY;
            ST_DRY:  state_next = ST_WET;
            ST_WET:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (last_ch)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ch_next    = CH_W'(ch_reg + 1'b1);
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (pos_reg == POS_W'(DELAY_DEPTH - 1))
                    begin
                        pos_next     = '0;
                        wrapped_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = POS_W'(pos_reg + 1'b1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            pos_reg       <= '0;
            wrapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                lp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            pos_reg       <= pos_next;
            wrapped_reg   <= wrapped_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_FB)
            begin
                lp_reg[ch_reg] <= s_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            x_reg[0] <= left_in;
            x_reg[1] <= right_in;
        end
        if (state_reg == ST_ADDR)
        begin
            rd_idx_reg <= rd_full[POS_W-1:0];
            rd_ok_reg  <= wrapped_reg || no_wrap;
        end
        if (state_reg == ST_DIFF)
        begin
            diff_reg <= OPA_W'(d_lp) - OPA_W'(lp_reg[ch_reg]);
        end
        if (state_reg == ST_OUT)
        begin
            res_reg[ch_reg] <= acc_sat;
        end
        if (load_out)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                out_reg[i] <= res_reg[i];
            end
        end
    end

    a_pos_moves_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != $past(pos_reg)) |-> ($past(state_reg) == ST_DONE))
        else $error("write position moved outside a transaction end");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised without a finished frame");

    a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        wrapped_reg |=> wrapped_reg)
        else $error("wrap flag cleared");

    a_first_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && $past(state_reg) == ST_ADDR) |-> (ch_reg == '0))
        else $error("frame did not start on channel zero");

endmodule

// ===== verif/feedback_echo_with_damping_test.sv =====
`timescale 1ns / 1ps

module feedback_echo_with_damping_test;
    import fewd_pkg::*;

    localparam int ADDR_W     = $clog2(DELAY_DEPTH_DEF);
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 500;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } frame_t;

    class echo_scoreboard;
        bit signed [SAMPLE_BITS-1:0] echo_mem [CHANNELS][DELAY_DEPTH_DEF];
        bit signed [LP_W-1:0]        lp_state [CHANNELS];
        bit [ADDR_W-1:0]             wr_pos;
        cfg_t                        cfg;
        frame_t                      expected_frames [$];
        int                          errors;

        function new();
            cfg = '{delay_samples: DELAY_RST, feedback_gain: FEEDBACK_RST,
                    tone_coeff: TONE_RST, mix_level: MIX_RST};
            wr_pos = '0;
            errors = 0;
        endfunction

        static function longint rnd_shift(longint v, int n);
            return (v + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        static function logic signed [SAMPLE_BITS-1:0] clip_sample(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
            begin
                v = hi;
            end
            else if (v < lo)
            begin
                v = lo;
            end
            return v[SAMPLE_BITS-1:0];
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DW-1:0] word);
            case (idx)
                REG_DELAY:    cfg.delay_samples = word[DLY_W-1:0];
                REG_FEEDBACK: cfg.feedback_gain = word[GAIN_W-1:0];
                REG_TONE:     cfg.tone_coeff    = word[TONE_W-1:0];
                REG_MIX:      cfg.mix_level     = word[MIX_W-1:0];
                default:      ;
            endcase
        endfunction

        // one echo step per accepted transaction
        function void note_frame(logic signed [SAMPLE_BITS-1:0] l,
                                 logic signed [SAMPLE_BITS-1:0] r);
            logic signed [SAMPLE_BITS-1:0] xin  [CHANNELS];
            logic signed [SAMPLE_BITS-1:0] yout [CHANNELS];
            bit [ADDR_W-1:0] rd;
            longint dly;
            longint wet;
            longint x;
            longint s;
            longint fb;
            frame_t f;
            dly = cfg.delay_samples;
            if (dly < 1)
            begin
                dly = 1;
            end
            else if (dly > DELAY_DEPTH_DEF - 2)
            begin
                dly = DELAY_DEPTH_DEF - 2;
            end
            wet = (cfg.mix_level > UNITY_GAIN) ? longint'(UNITY_GAIN) : longint'(cfg.mix_level);
            rd = wr_pos - ADDR_W'(dly);
            xin[0] = l;
            xin[1] = r;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                x = xin[ch];
                s = lp_state[ch];
                s += rnd_shift(longint'(cfg.tone_coeff)
                               * ((longint'(echo_mem[ch][rd]) <<< LP_EXTRA) - s), COEF_SHIFT);
                lp_state[ch] = s[LP_W-1:0];
                fb = rnd_shift(s * longint'(cfg.feedback_gain), OUT_SHIFT);
                echo_mem[ch][wr_pos] = clip_sample(x + fb);
                yout[ch] = clip_sample(rnd_shift((x <<< LP_EXTRA) * (longint'(UNITY_GAIN) - wet)
                                                 + s * wet, OUT_SHIFT));
            end
            wr_pos++;
            f.left  = yout[0];
            f.right = yout[1];
            expected_frames.insert(expected_frames.size(), f);
        endfunction

        function void check_frame(logic signed [SAMPLE_BITS-1:0] l,
                                  logic signed [SAMPLE_BITS-1:0] r);
            frame_t want;
            if (expected_frames.size() == 0)
            begin
                $display("%0t: unexpected output transaction left=%0d right=%0d", $time, l, r);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            if (l !== want.left)
            begin
                $display("%0t: left_out mismatch: expected %0d, actual %0d",
                         $time, want.left, l);
                errors++;
            end
            if (r !== want.right)
            begin
                $display("%0t: right_out mismatch: expected %0d, actual %0d",
                         $time, want.right, r);
                errors++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] left_in   = '0;
    logic signed [SAMPLE_BITS-1:0] right_in  = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [CFG_AW-1:0]             paddr     = '0;
    logic [CFG_DW-1:0]             pwdata    = '0;
    logic [CFG_DW-1:0]             prdata;
    logic                          pready;

    bit             steady = 1'b0;
    echo_scoreboard sb     = new();

    feedback_echo_with_damping uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // upper bits above the register width are random and must be dropped
    task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
        int unsigned keep;
        int unsigned mask;
        int unsigned word;
        case (idx)
            REG_DELAY:    keep = DLY_W;
            REG_FEEDBACK: keep = GAIN_W;
            REG_TONE:     keep = TONE_W;
            default:      keep = MIX_W;
        endcase
        mask = (32'd1 << keep) - 1;
        word = ($urandom & ~mask) | (value & mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, word);
    endtask

    task automatic set_all(input int unsigned dly, input int unsigned fbk,
                           input int unsigned tone, input int unsigned mix);
        set_reg(REG_DELAY, dly);
        set_reg(REG_FEEDBACK, fbk);
        set_reg(REG_TONE, tone);
        set_reg(REG_MIX, mix);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] l,
                              input logic signed [SAMPLE_BITS-1:0] r);
        while (!steady && $urandom_range(0, 99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        left_in  <= l;
        right_in <= r;
        do @(posedge clk); while (in_stall);
        sb.note_frame(l, r);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        int v;
        case ($urandom_range(0, 7))
            0:       v = 32767;
            1:       v = -32768;
            2, 3:    v = int'($urandom_range(0, 64)) - 32;
            default: v = $urandom;
        endcase
        return v[SAMPLE_BITS-1:0];
    endfunction

    // output side: random stall plus one long hold to back up the input
    initial
    begin : sink
        int taken;
        int hold;
        taken = 0;
        hold  = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                sb.check_frame(left_out, right_out);
                taken++;
                if (taken == HOLD_AT)
                begin
                    hold = HOLD_LEN;
                end
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !steady && ($urandom_range(0, 99) < 18);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (psel && penable))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("feedback_echo_with_damping regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned dly;
        int unsigned fbk;
        int unsigned tone;
        int unsigned mix;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, extreme samples
        send_frame(32767, -32768);
        send_frame(-32768, 32767);
        send_frame(0, 0);
        send_frame(-1, 1);
        send_frame(16'sh5555, 16'shAAAA);
        settle();

        // zero delay, feedback just below unity, largest coefficient, wet share past range
        set_all(0, 65535, 32767, 131071);
        for (int i = 0; i < 8; i++)
        begin
            send_frame(32767, -32768);
        end
        send_frame(0, 0);
        send_frame(0, 0);
        settle();

        // delay past the clamp limit, no feedback, frozen lowpass, fully dry
        set_all(DELAY_DEPTH_DEF - 1, 0, 0, 0);
        send_frame(-32768, 32767);
        send_frame(1, -1);
        send_frame(32767, 0);
        send_frame(0, -32768);
        settle();

        set_all(2, 62259, 1311, 65536);
        send_frame(12345, -12345);
        send_frame(-32768, -32768);
        send_frame(32767, 32767);
        send_frame(0, 0);
        send_frame(100, -100);
        settle();

        for (int phase = 0; phase < 5; phase++)
        begin
            case ($urandom_range(0, 7))
                0:       dly = 0;
                1:       dly = 1;
                2:       dly = DELAY_DEPTH_DEF - 2;
                3:       dly = DELAY_DEPTH_DEF - 1;
                4:       dly = $urandom_range(1, 16);
                7:       dly = $urandom_range(0, DELAY_DEPTH_DEF - 1);
                default: dly = $urandom_range(2, 600);
            endcase
            case ($urandom_range(0, 3))
                0:       fbk = 0;
                1:       fbk = 65535;
                default: fbk = $urandom_range(0, 62259);
            endcase
            case ($urandom_range(0, 4))
                0:       tone = 0;
                1:       tone = 32767;
                default: tone = $urandom_range(1311, 22938);
            endcase
            case ($urandom_range(0, 4))
                0:       mix = 0;
                1:       mix = 65536;
                2:       mix = $urandom_range(65537, 131071);
                default: mix = $urandom_range(0, 65536);
            endcase
            set_all(dly, fbk, tone, mix);
            steady = (phase == 2);
            repeat (200)
            begin
                send_frame(rand_sample(), rand_sample());
            end
            settle();
        end
        steady = 1'b0;

        repeat (40) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("feedback_echo_with_damping regression: pass");
        end
        else
        begin
            $display("feedback_echo_with_damping regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fewd_pkg.sv
rtl/fewd_cfg.sv
rtl/fewd_mac.sv
rtl/fewd_mem.sv
rtl/feedback_echo_with_damping.sv
verif/feedback_echo_with_damping_test.sv
